FILE: rtl/mats_pkg.sv
package mats_pkg;

   // Request operation codes.
   localparam logic [2:0] OP_ADD   = 3'd0;
   localparam logic [2:0] OP_AVG   = 3'd1;
   localparam logic [2:0] OP_CLEAR = 3'd2;
   localparam logic [2:0] OP_FILL  = 3'd3;
   localparam logic [2:0] OP_READ  = 3'd4;

   // Configuration register indexes (byte address bit 2).
   localparam logic REG_WINDOW_SIZE  = 1'b0;
   localparam logic REG_HISTORY_SIZE = 1'b1;

   // Widths that hold the largest supported window and history depths.
   localparam int CFG_WS_W = 8;
   localparam int CFG_HS_W = 7;

   typedef struct packed {
      logic [CFG_WS_W-1:0] window_size;
      logic [CFG_HS_W-1:0] history_size;
      logic                clear;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         op;
      logic signed [15:0] sample;
      logic [14:0]        fill_count;
      logic [7:0]         index;
   } req_type;

   typedef struct packed {
      logic signed [15:0] average;
      logic               average_valid;
      logic signed [15:0] weighted_average;
      logic               weighted_valid;
      logic signed [31:0] slope;
      logic               slope_valid;
      logic signed [15:0] element;
      logic               element_valid;
   } res_type;

endpackage

FILE: rtl/mats_req_if.sv
interface mats_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         op;
   logic signed [15:0] sample;
   logic [14:0]        fill_count;
   logic [7:0]         index;

   modport source(output valid, op, sample, fill_count, index, input ready);
   modport sink(input valid, op, sample, fill_count, index, output ready);
endinterface

FILE: rtl/mats_rsp_if.sv
interface mats_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] average;
   logic               average_valid;
   logic signed [15:0] weighted_average;
   logic               weighted_valid;
   logic signed [31:0] slope;
   logic               slope_valid;
   logic signed [15:0] element;
   logic               element_valid;

   modport source(output valid, average, average_valid, weighted_average, weighted_valid,
                  slope, slope_valid, element, element_valid, input ready);
   modport sink(input valid, average, average_valid, weighted_average, weighted_valid,
                slope, slope_valid, element, element_valid, output ready);
endinterface

FILE: rtl/moving_average_trend_slope_unit.sv
// Moving average and trend slope unit. Each request carries one operation
// (add a sample, take the average and push it into the history ring, clear,
// fill with a repeated value, or read an element) and yields exactly one
// response with the plain average, the linearly weighted average, the
// least-squares slope of the average history in saturated Q16.16 and the
// requested ring element, each with a valid flag (the weighted average shares
// the average's). Requests are handled one at a time by a small sequencer
// around a single shared multiplier and a shared one-bit-per-cycle divider of
// DIV_W bits (DIV_W is 54 at the default depths). The run time of a request
// grows with the number of divisions (up to three), the stored sample count
// and, when the history is full, the history size; a fill also writes each
// stored copy and adds one more division. The divider sets most of the run
// time. The response sits in an output register, so the next request is taken
// as soon as the result has moved there. The two configuration registers lie
// at byte addresses 0 (window_size) and 4 (history_size); values are clamped
// to their legal range and any write clears both rings. Write configuration
// only while no request is in flight.
module moving_average_trend_slope_unit #(
   parameter int WINDOW_DEPTH  = 16,
   parameter int HISTORY_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   mats_req_if.sink    req,
   mats_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import mats_pkg::*;

   logic [CFG_WS_W-1:0] ws_ff, ws_in;
   logic [CFG_HS_W-1:0] hs_ff, hs_in;
   logic                cfg_write;
   logic [CFG_WS_W-1:0] ws_raw;
   logic [CFG_HS_W-1:0] hs_raw;
   cfg_type             cfg;
   req_type             core_req;
   res_type             core_res;
   logic                core_res_valid;
   logic                core_res_ready;
   res_type             rsp_data_ff;
   logic                rsp_valid_ff;

   // The configuration port completes a write in its access cycle.
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign ws_raw     = CFG_WS_W'(csr_pwdata[4:0]);
   assign hs_raw     = CFG_HS_W'(csr_pwdata[3:0]);

   // Clamp written values into the legal ranges of the two registers.
   always_comb begin
      ws_in = ws_ff;
      hs_in = hs_ff;
      if (cfg_write) begin
         unique case (csr_paddr[2])
            REG_WINDOW_SIZE: begin
               if (ws_raw == '0) begin
                  ws_in = CFG_WS_W'(1);
               end else if (ws_raw > CFG_WS_W'(WINDOW_DEPTH)) begin
                  ws_in = CFG_WS_W'(WINDOW_DEPTH);
               end else begin
                  ws_in = ws_raw;
               end
            end
            REG_HISTORY_SIZE: begin
               if (hs_raw < CFG_HS_W'(2)) begin
                  hs_in = CFG_HS_W'(2);
               end else if (hs_raw > CFG_HS_W'(HISTORY_DEPTH)) begin
                  hs_in = CFG_HS_W'(HISTORY_DEPTH);
               end else begin
                  hs_in = hs_raw;
               end
            end
            default: begin
               ws_in = ws_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ws_ff <= CFG_WS_W'(WINDOW_DEPTH);
         hs_ff <= CFG_HS_W'(HISTORY_DEPTH);
      end else begin
         ws_ff <= ws_in;
         hs_ff <= hs_in;
      end
   end

   assign csr_prdata = (csr_paddr[2] == REG_HISTORY_SIZE) ? 32'(hs_ff) : 32'(ws_ff);

   // Any register write empties both rings.
   assign cfg.window_size  = ws_ff;
   assign cfg.history_size = hs_ff;
   assign cfg.clear        = cfg_write;

   assign core_req.op         = req.op;
   assign core_req.sample     = req.sample;
   assign core_req.fill_count = req.fill_count;
   assign core_req.index      = req.index;

   mats_core #(.WD(WINDOW_DEPTH), .HD(HISTORY_DEPTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_req    (core_req),
      .res_valid (core_res_valid),
      .res_ready (core_res_ready),
      .res       (core_res)
   );

   // Output register: the sequencer hands over a response whenever the
   // register is empty or is being drained in the same cycle.
   assign core_res_ready = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (core_res_valid && core_res_ready) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (core_res_valid && core_res_ready) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.average          = rsp_data_ff.average;
   assign rsp.average_valid    = rsp_data_ff.average_valid;
   assign rsp.weighted_average = rsp_data_ff.weighted_average;
   assign rsp.weighted_valid   = rsp_data_ff.weighted_valid;
   assign rsp.slope            = rsp_data_ff.slope;
   assign rsp.slope_valid      = rsp_data_ff.slope_valid;
   assign rsp.element          = rsp_data_ff.element;
   assign rsp.element_valid    = rsp_data_ff.element_valid;

   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp.ready) |=> rsp_valid_ff)
      else $error("pending response dropped");
   assert property (@(posedge clock) disable iff (reset)
                    (core_res_valid && core_res_ready) |=> rsp_valid_ff)
      else $error("response not captured");
   assert property (@(posedge clock) disable iff (reset)
                    ws_ff != '0 && hs_ff >= CFG_HS_W'(2))
      else $error("configuration register out of range");
endmodule

FILE: rtl/mats_div.sv
module mats_div #(
   parameter int W = 54
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [W-1:0] num,
   input  logic [W-1:0] den,
   output logic         busy,
   output logic         done,
   output logic [W-1:0] quot,
   output logic [W-1:0] rem
);
   localparam int CW = $clog2(W + 1);

   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  quo_ff, quo_in;
   logic [W-1:0]  den_ff, den_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in;
   logic          done_ff, done_in;
   logic [W:0]    shifted;
   logic [W:0]    diff;

   // One quotient bit per cycle, restoring.
   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      shifted = {rem_ff, quo_ff[W-1]};
      diff    = shifted - {1'b0, den_ff};
      if (busy_ff) begin
         if (!diff[W]) begin
            rem_in = diff[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b1};
         end else begin
            rem_in = shifted[W-1:0];
            quo_in = {quo_ff[W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(W);
         busy_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = quo_ff;
   assign rem  = rem_ff;

   assert property (@(posedge clock) disable iff (reset) done_ff |-> !busy_ff)
      else $error("divider reports done while still busy");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> cnt_ff != '0)
      else $error("divider busy with an empty step count");
   assert property (@(posedge clock) disable iff (reset) (start && !busy_ff) |=> busy_ff)
      else $error("divider did not start");
endmodule

FILE: rtl/mats_core.sv
module mats_core #(
   parameter int WD = 16,
   parameter int HD = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  mats_pkg::cfg_type cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  mats_pkg::req_type in_req,
   output logic              res_valid,
   input  logic              res_ready,
   output mats_pkg::res_type res
);
   import mats_pkg::*;

   localparam int SW     = (WD > 1) ? $clog2(WD) : 1;
   localparam int HSW    = $clog2(HD);
   localparam int CNT_W  = $clog2(WD + 1);
   localparam int HCNT_W = $clog2(HD + 1);
   localparam int KW     = (CNT_W > HCNT_W) ? CNT_W : HCNT_W;
   localparam int LW     = (SW > HSW) ? SW : HSW;
   localparam int SUM_W  = 16 + CNT_W;
   localparam int HSUM_W = 16 + HCNT_W;
   localparam int MA_W   = (HSUM_W > 17) ? HSUM_W : 17;
   localparam int MB_W   = KW + 1;
   localparam int P_W    = MA_W + MB_W + 1;
   localparam int ACC_W  = P_W + KW;
   localparam int D_W    = ACC_W + 5;
   localparam int DIV_W  = D_W + 17;

   localparam logic [DIV_W-1:0] POS_MAX = DIV_W'(64'd2147483647);
   localparam logic [DIV_W-1:0] NEG_MAG = DIV_W'(64'd2147483648);

   typedef enum logic [25:0] {
      S_IDLE     = 26'd1 << 0,
      S_DISPATCH = 26'd1 << 1,
      S_ADD      = 26'd1 << 2,
      S_FILL     = 26'd1 << 3,
      S_FMOD     = 26'd1 << 4,
      S_FWAIT    = 26'd1 << 5,
      S_AVG      = 26'd1 << 6,
      S_AVGW     = 26'd1 << 7,
      S_PUSHR    = 26'd1 << 8,
      S_PUSHW    = 26'd1 << 9,
      S_WINIT    = 26'd1 << 10,
      S_WRD      = 26'd1 << 11,
      S_WMUL     = 26'd1 << 12,
      S_WACC     = 26'd1 << 13,
      S_WDEN     = 26'd1 << 14,
      S_WDIV     = 26'd1 << 15,
      S_WWAIT    = 26'd1 << 16,
      S_SINIT    = 26'd1 << 17,
      S_SL1      = 26'd1 << 18,
      S_SL2      = 26'd1 << 19,
      S_SL3      = 26'd1 << 20,
      S_SL4      = 26'd1 << 21,
      S_SWAIT    = 26'd1 << 22,
      S_ERD      = 26'd1 << 23,
      S_EOUT     = 26'd1 << 24,
      S_DONE     = 26'd1 << 25
   } state_type;

   state_type state_ff, state_in;

   // Captured request.
   logic [2:0]         op_ff, op_in;
   logic signed [15:0] smp_ff, smp_in;
   logic [14:0]        fcnt_ff, fcnt_in;
   logic [7:0]         idx_ff, idx_in;

   // Window and history state.
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [SW-1:0]            wslot_ff, wslot_in;
   logic [CNT_W-1:0]         cnt_ff, cnt_in;
   logic signed [HSUM_W-1:0] hsum_ff, hsum_in;
   logic [HSW-1:0]           hslot_ff, hslot_in;
   logic [HCNT_W-1:0]        hcnt_ff, hcnt_in;

   // Walk and arithmetic working registers.
   logic                     walk_hist_ff, walk_hist_in;
   logic [LW-1:0]            walk_slot_ff, walk_slot_in;
   logic [KW-1:0]            weight_ff, weight_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [CNT_W-1:0]         fill_k_ff, fill_k_in;
   logic signed [D_W-1:0]    d_ff, d_in;
   logic                     neg_ff, neg_in;
   logic signed [MA_W-1:0]   mul_a;
   logic [MB_W-1:0]          mul_b;
   logic signed [P_W-1:0]    prod_ff, prod_in;

   // Results.
   logic signed [15:0] avg_ff, avg_in;
   logic               avg_ok_ff, avg_ok_in;
   logic signed [15:0] wavg_ff, wavg_in;
   logic signed [31:0] slope_ff, slope_in;
   logic               slope_ok_ff, slope_ok_in;
   logic signed [15:0] elem_ff, elem_in;
   logic               elem_ok_ff, elem_ok_in;

   // Memories.
   logic signed [15:0] samp_mem [WD];
   logic signed [15:0] hist_mem [HD];
   logic [SW-1:0]      s_rd_addr, s_waddr;
   logic [HSW-1:0]     h_rd_addr, h_waddr;
   logic               s_we, h_we;
   logic signed [15:0] s_wdata, h_wdata;
   logic signed [15:0] s_rdata_ff, h_rdata_ff;
   logic signed [15:0] walk_rdata;

   // Divider.
   logic             div_start, div_busy, div_done;
   logic [DIV_W-1:0] div_num, div_den, div_quot, div_rem;

   logic [CNT_W-1:0]  ws;
   logic [HCNT_W-1:0] hs;
   logic [KW-1:0]     walk_len;
   logic [KW:0]       start_slot;
   logic [CNT_W-1:0]  stored;
   logic [CNT_W-1:0]  fill_kp1;
   logic [SUM_W-1:0]  sum_mag;
   logic [ACC_W-1:0]  acc_mag;
   logic [D_W-1:0]    d_mag;
   logic signed [D_W-1:0] acc_x, prod_x;
   logic signed [15:0] old_val;

   assign ws         = CNT_W'(cfg.window_size);
   assign hs         = HCNT_W'(cfg.history_size);
   assign walk_len   = walk_hist_ff ? KW'(hs) : KW'(cnt_ff);
   assign walk_rdata = walk_hist_ff ? h_rdata_ff : s_rdata_ff;
   assign stored     = (16'(fcnt_ff) < 16'(ws)) ? CNT_W'(fcnt_ff) : ws;
   assign fill_kp1   = fill_k_ff + CNT_W'(1);
   assign sum_mag    = sum_ff[SUM_W-1] ? $unsigned(-sum_ff) : $unsigned(sum_ff);
   assign acc_mag    = acc_ff[ACC_W-1] ? $unsigned(-acc_ff) : $unsigned(acc_ff);
   assign d_mag      = d_ff[D_W-1] ? $unsigned(-d_ff) : $unsigned(d_ff);
   assign acc_x      = D_W'(acc_ff);
   assign prod_x     = D_W'(prod_ff);
   assign prod_in    = mul_a * $signed({1'b0, mul_b});

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      smp_in       = smp_ff;
      fcnt_in      = fcnt_ff;
      idx_in       = idx_ff;
      sum_in       = sum_ff;
      wslot_in     = wslot_ff;
      cnt_in       = cnt_ff;
      hsum_in      = hsum_ff;
      hslot_in     = hslot_ff;
      hcnt_in      = hcnt_ff;
      walk_hist_in = walk_hist_ff;
      walk_slot_in = walk_slot_ff;
      weight_in    = weight_ff;
      acc_in       = acc_ff;
      fill_k_in    = fill_k_ff;
      d_in         = d_ff;
      neg_in       = neg_ff;
      avg_in       = avg_ff;
      avg_ok_in    = avg_ok_ff;
      wavg_in      = wavg_ff;
      slope_in     = slope_ff;
      slope_ok_in  = slope_ok_ff;
      elem_in      = elem_ff;
      elem_ok_in   = elem_ok_ff;
      mul_a        = '0;
      mul_b        = '0;
      s_rd_addr    = '0;
      h_rd_addr    = '0;
      s_we         = 1'b0;
      s_waddr      = '0;
      s_wdata      = smp_ff;
      h_we         = 1'b0;
      h_waddr      = hslot_ff;
      h_wdata      = avg_ff;
      div_start    = 1'b0;
      div_num      = '0;
      div_den      = '0;
      start_slot   = '0;
      old_val      = '0;
      in_ready     = 1'b0;
      res_valid    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // A register write in this cycle takes priority over a request.
            in_ready = !cfg.clear;
            if (cfg.clear) begin
               sum_in   = '0;
               wslot_in = '0;
               cnt_in   = '0;
               hsum_in  = '0;
               hslot_in = '0;
               hcnt_in  = '0;
            end else if (in_valid) begin
               op_in    = in_req.op;
               smp_in   = in_req.sample;
               fcnt_in  = in_req.fill_count;
               idx_in   = in_req.index;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_AVG;
            unique case (op_ff)
               OP_ADD: begin
                  s_rd_addr = wslot_ff;
                  state_in  = S_ADD;
               end
               OP_CLEAR, OP_FILL: begin
                  sum_in    = '0;
                  wslot_in  = '0;
                  cnt_in    = '0;
                  hsum_in   = '0;
                  hslot_in  = '0;
                  hcnt_in   = '0;
                  fill_k_in = '0;
                  if (op_ff == OP_FILL && fcnt_ff != '0) begin
                     state_in = S_FILL;
                  end
               end
               default: begin
                  state_in = S_AVG;
               end
            endcase
         end
         S_ADD: begin
            // The slot under the write pointer holds a live sample only once full.
            old_val  = (cnt_ff == ws) ? s_rdata_ff : 16'sd0;
            sum_in   = sum_ff - SUM_W'(old_val) + SUM_W'(smp_ff);
            s_we     = 1'b1;
            s_waddr  = wslot_ff;
            wslot_in = (CNT_W'(wslot_ff) + CNT_W'(1) >= ws) ? '0 : wslot_ff + SW'(1);
            if (cnt_ff < ws) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            state_in = S_AVG;
         end
         S_FILL: begin
            s_we      = 1'b1;
            s_waddr   = SW'(fill_k_ff);
            sum_in    = sum_ff + SUM_W'(smp_ff);
            fill_k_in = fill_kp1;
            if (fill_kp1 == stored) begin
               cnt_in   = stored;
               state_in = S_FMOD;
            end
         end
         S_FMOD: begin
            div_start = 1'b1;
            div_num   = DIV_W'(fcnt_ff);
            div_den   = DIV_W'(ws);
            state_in  = S_FWAIT;
         end
         S_FWAIT: begin
            if (div_done) begin
               wslot_in = SW'(div_rem);
               state_in = S_AVG;
            end
         end
         S_AVG: begin
            if (cnt_ff == '0) begin
               avg_in    = '0;
               avg_ok_in = 1'b0;
               wavg_in   = '0;
               state_in  = S_SINIT;
            end else begin
               neg_in    = sum_ff[SUM_W-1];
               div_start = 1'b1;
               div_num   = DIV_W'(sum_mag);
               div_den   = DIV_W'(cnt_ff);
               state_in  = S_AVGW;
            end
         end
         S_AVGW: begin
            if (div_done) begin
               avg_in    = neg_ff ? 16'(-div_quot) : 16'(div_quot);
               avg_ok_in = 1'b1;
               state_in  = (op_ff == OP_AVG) ? S_PUSHR : S_WINIT;
            end
         end
         S_PUSHR: begin
            h_rd_addr = hslot_ff;
            state_in  = S_PUSHW;
         end
         S_PUSHW: begin
            old_val  = (hcnt_ff == hs) ? h_rdata_ff : 16'sd0;
            hsum_in  = hsum_ff - HSUM_W'(old_val) + HSUM_W'(avg_ff);
            h_we     = 1'b1;
            hslot_in = (HCNT_W'(hslot_ff) + HCNT_W'(1) >= hs) ? '0 : hslot_ff + HSW'(1);
            if (hcnt_ff < hs) begin
               hcnt_in = hcnt_ff + HCNT_W'(1);
            end
            state_in = S_WINIT;
         end
         S_WINIT: begin
            start_slot = (KW+1)'(wslot_ff) + (KW+1)'(cnt_ff) - (KW+1)'(1);
            if (start_slot >= (KW+1)'(cnt_ff)) begin
               start_slot = start_slot - (KW+1)'(cnt_ff);
            end
            walk_hist_in = 1'b0;
            walk_slot_in = LW'(start_slot);
            weight_in    = KW'(cnt_ff);
            acc_in       = '0;
            state_in     = S_WRD;
         end
         S_WRD: begin
            s_rd_addr    = SW'(walk_slot_ff);
            h_rd_addr    = HSW'(walk_slot_ff);
            walk_slot_in = (walk_slot_ff == '0) ? LW'(walk_len - KW'(1))
                                                : walk_slot_ff - LW'(1);
            state_in     = S_WMUL;
         end
         S_WMUL: begin
            mul_a    = MA_W'(walk_rdata);
            mul_b    = MB_W'(weight_ff);
            state_in = S_WACC;
         end
         S_WACC: begin
            acc_in    = acc_ff + ACC_W'(prod_ff);
            weight_in = weight_ff - KW'(1);
            if (weight_ff == KW'(1)) begin
               state_in = walk_hist_ff ? S_SL1 : S_WDEN;
            end else begin
               state_in = S_WRD;
            end
         end
         S_WDEN: begin
            mul_a    = $signed(MA_W'(cnt_ff));
            mul_b    = MB_W'(cnt_ff) + MB_W'(1);
            state_in = S_WDIV;
         end
         S_WDIV: begin
            neg_in    = acc_ff[ACC_W-1];
            div_start = 1'b1;
            div_num   = DIV_W'(acc_mag);
            div_den   = DIV_W'($unsigned(prod_ff) >> 1);
            state_in  = S_WWAIT;
         end
         S_WWAIT: begin
            if (div_done) begin
               wavg_in  = neg_ff ? 16'(-div_quot) : 16'(div_quot);
               state_in = S_SINIT;
            end
         end
         S_SINIT: begin
            if (hcnt_ff != hs) begin
               slope_in    = '0;
               slope_ok_in = 1'b0;
               state_in    = S_ERD;
            end else begin
               start_slot = (KW+1)'(hslot_ff) + (KW+1)'(hs) - (KW+1)'(1);
               if (start_slot >= (KW+1)'(hs)) begin
                  start_slot = start_slot - (KW+1)'(hs);
               end
               walk_hist_in = 1'b1;
               walk_slot_in = LW'(start_slot);
               weight_in    = KW'(hs);
               acc_in       = '0;
               state_in     = S_WRD;
            end
         end
         S_SL1: begin
            mul_a    = MA_W'(hsum_ff);
            mul_b    = MB_W'(hs) + MB_W'(1);
            state_in = S_SL2;
         end
         S_SL2: begin
            // Numerator 12*W - 6*(m+1)*S; the factors 12 and 6 by shift and add.
            d_in     = (acc_x <<< 3) + (acc_x <<< 2) - (prod_x <<< 2) - (prod_x <<< 1);
            mul_a    = $signed(MA_W'(hs));
            mul_b    = MB_W'(hs) - MB_W'(1);
            state_in = S_SL3;
         end
         S_SL3: begin
            mul_a    = MA_W'(prod_ff);
            mul_b    = MB_W'(hs) + MB_W'(1);
            state_in = S_SL4;
         end
         S_SL4: begin
            neg_in    = d_ff[D_W-1];
            div_start = 1'b1;
            div_num   = DIV_W'({d_mag, 16'b0}) + DIV_W'($unsigned(prod_ff) >> 1);
            div_den   = DIV_W'($unsigned(prod_ff));
            state_in  = S_SWAIT;
         end
         S_SWAIT: begin
            if (div_done) begin
               if (neg_ff) begin
                  slope_in = (div_quot > NEG_MAG) ? 32'sh80000000 : 32'(-div_quot);
               end else begin
                  slope_in = (div_quot > POS_MAX) ? 32'sh7fffffff : 32'(div_quot);
               end
               slope_ok_in = 1'b1;
               state_in    = S_ERD;
            end
         end
         S_ERD: begin
            s_rd_addr = idx_ff[SW-1:0];
            state_in  = S_EOUT;
         end
         S_EOUT: begin
            elem_ok_in = 9'(idx_ff) < 9'(cnt_ff);
            elem_in    = (9'(idx_ff) < 9'(cnt_ff)) ? s_rdata_ff : 16'sd0;
            state_in   = S_DONE;
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sum_ff   <= '0;
         wslot_ff <= '0;
         cnt_ff   <= '0;
         hsum_ff  <= '0;
         hslot_ff <= '0;
         hcnt_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         wslot_ff <= wslot_in;
         cnt_ff   <= cnt_in;
         hsum_ff  <= hsum_in;
         hslot_ff <= hslot_in;
         hcnt_ff  <= hcnt_in;
      end
      op_ff        <= op_in;
      smp_ff       <= smp_in;
      fcnt_ff      <= fcnt_in;
      idx_ff       <= idx_in;
      walk_hist_ff <= walk_hist_in;
      walk_slot_ff <= walk_slot_in;
      weight_ff    <= weight_in;
      acc_ff       <= acc_in;
      fill_k_ff    <= fill_k_in;
      d_ff         <= d_in;
      neg_ff       <= neg_in;
      prod_ff      <= prod_in;
      avg_ff       <= avg_in;
      avg_ok_ff    <= avg_ok_in;
      wavg_ff      <= wavg_in;
      slope_ff     <= slope_in;
      slope_ok_ff  <= slope_ok_in;
      elem_ff      <= elem_in;
      elem_ok_ff   <= elem_ok_in;
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         samp_mem[s_waddr] <= s_wdata;
      end
      s_rdata_ff <= samp_mem[s_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (h_we) begin
         hist_mem[h_waddr] <= h_wdata;
      end
      h_rdata_ff <= hist_mem[h_rd_addr];
   end

   mats_div #(.W(DIV_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_quot),
      .rem   (div_rem)
   );

   assign res.average          = avg_ff;
   assign res.average_valid    = avg_ok_ff;
   assign res.weighted_average = wavg_ff;
   assign res.weighted_valid   = avg_ok_ff;
   assign res.slope            = slope_ff;
   assign res.slope_valid      = slope_ok_ff;
   assign res.element          = elem_ff;
   assign res.element_valid    = elem_ok_ff;

   assert property (@(posedge clock) disable iff (reset) cnt_ff <= ws)
      else $error("sample count above the window size");
   assert property (@(posedge clock) disable iff (reset) hcnt_ff <= hs)
      else $error("history count above the history size");
   assert property (@(posedge clock) disable iff (reset) div_start |-> !div_busy)
      else $error("divider started while busy");
   assert property (@(posedge clock) disable iff (reset)
                    (in_valid && in_ready && !cfg.clear) |=> state_ff == S_DISPATCH)
      else $error("accepted request was not dispatched");
endmodule
